>>> hw/rtl/masked_2d_pattern_match_assert.svh
// Assertion macros shared by the masked pattern match RTL.
`ifndef MASKED_2D_PATTERN_MATCH_ASSERT_SVH
`define MASKED_2D_PATTERN_MATCH_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define M2PM_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define M2PM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/m2pm_pkg.sv
// Shared types and constants of the masked pattern match block.
package m2pm_pkg;

	// Default store sizes
	localparam int DEF_MAX_IMAGE_ROWS = 64;
	localparam int DEF_MAX_IMAGE_COLS = 64;
	localparam int DEF_MAX_MASK_ROWS  = 8;
	localparam int DEF_MAX_MASK_COLS  = 8;

	// Word field and register widths
	localparam int REQ_W      = 2;
	localparam int CELL_W     = 6;
	localparam int VAL_W      = 8;
	localparam int IMG_SZ_W   = 7;
	localparam int MSK_SZ_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Register reset values
	localparam logic [IMG_SZ_W-1:0] RST_IMAGE_ROWS = 7'd64;
	localparam logic [IMG_SZ_W-1:0] RST_IMAGE_COLS = 7'd64;
	localparam logic [MSK_SZ_W-1:0] RST_MASK_ROWS  = 4'd8;
	localparam logic [MSK_SZ_W-1:0] RST_MASK_COLS  = 4'd8;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_IMAGE  = 2'd0,
		REQ_MASK   = 2'd1,
		REQ_SEARCH = 2'd2
	} req_t;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_ROWS = 2'd0,
		REG_IMAGE_COLS = 2'd1,
		REG_MASK_ROWS  = 2'd2,
		REG_MASK_COLS  = 2'd3
	} reg_idx_t;

	// Controller to datapath commands
	typedef struct packed {
		logic start;
		logic issue;
		logic wr_img;
		logic wr_mask;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic sizes_ok;
		logic issue_last;
		logic hit;
		logic done;
	} dp_sts_t;

endpackage

>>> hw/rtl/m2pm_dpath.sv
// Datapath: size registers, image and mask memories, placement walk and compare.
module m2pm_dpath
	import m2pm_pkg::*;
#(
	parameter int MAX_IMAGE_ROWS = DEF_MAX_IMAGE_ROWS,
	parameter int MAX_IMAGE_COLS = DEF_MAX_IMAGE_COLS,
	parameter int MAX_MASK_ROWS  = DEF_MAX_MASK_ROWS,
	parameter int MAX_MASK_COLS  = DEF_MAX_MASK_COLS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CELL_W-1:0]     cell_row,
	input  logic [CELL_W-1:0]     cell_col,
	input  logic [VAL_W-1:0]      cell_value,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts
);

	localparam int IRW = $clog2(MAX_IMAGE_ROWS + 1);
	localparam int ICW = $clog2(MAX_IMAGE_COLS + 1);
	localparam int MRW = $clog2(MAX_MASK_ROWS + 1);
	localparam int MCW = $clog2(MAX_MASK_COLS + 1);
	localparam int RW  = (IRW > MRW) ? IRW : MRW;
	localparam int CW  = (ICW > MCW) ? ICW : MCW;
	localparam int SW0 = (RW > CW) ? RW : CW;
	localparam int SW  = (SW0 > IMG_SZ_W) ? SW0 : IMG_SZ_W;
	localparam int IDEPTH = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
	localparam int MDEPTH = MAX_MASK_ROWS * MAX_MASK_COLS;
	localparam int IAW = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
	localparam int MAW = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam logic [IAW-1:0] ICOLS = IAW'(MAX_IMAGE_COLS);
	localparam logic [MAW-1:0] MCOLS = MAW'(MAX_MASK_COLS);

	logic [IMG_SZ_W-1:0] image_rows_q, image_cols_q;
	logic [MSK_SZ_W-1:0] mask_rows_q, mask_cols_q;
	logic [RW-1:0]       ir, mr, r0_q, r_q, irow;
	logic [CW-1:0]       ic, mc, c0_q, c_q, icol;
	logic                last_c, last_r, last_c0, last_r0;
	logic [IAW-1:0]      img_raddr, img_waddr;
	logic [MAW-1:0]      mask_raddr, mask_waddr;
	logic                img_in_range, mask_in_range;
	logic [VAL_W-1:0]    img_mem [IDEPTH];
	logic [VAL_W-1:0]    mask_mem [MDEPTH];
	logic [VAL_W-1:0]    img_s1, mask_s1;
	logic                valid_s1, last_cell_s1, last_all_s1;
	logic                fail_q, cared_q;
	logic                mask_nz, mis;

	// Hold the size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= RST_IMAGE_ROWS;
			image_cols_q <= RST_IMAGE_COLS;
			mask_rows_q  <= RST_MASK_ROWS;
			mask_cols_q  <= RST_MASK_COLS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_ROWS: image_rows_q <= cfg_data[IMG_SZ_W-1:0];
				REG_IMAGE_COLS: image_cols_q <= cfg_data[IMG_SZ_W-1:0];
				REG_MASK_ROWS:  mask_rows_q  <= cfg_data[MSK_SZ_W-1:0];
				REG_MASK_COLS:  mask_cols_q  <= cfg_data[MSK_SZ_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp sizes to the store dimensions
	always_comb begin
		ir = (SW'(image_rows_q) > SW'(MAX_IMAGE_ROWS)) ? RW'(MAX_IMAGE_ROWS) : RW'(image_rows_q);
		ic = (SW'(image_cols_q) > SW'(MAX_IMAGE_COLS)) ? CW'(MAX_IMAGE_COLS) : CW'(image_cols_q);
		mr = (SW'(mask_rows_q) > SW'(MAX_MASK_ROWS)) ? RW'(MAX_MASK_ROWS) : RW'(mask_rows_q);
		mc = (SW'(mask_cols_q) > SW'(MAX_MASK_COLS)) ? CW'(MAX_MASK_COLS) : CW'(mask_cols_q);
	end

	// Detect the end of each walk level
	assign last_c  = (c_q == mc - 1'b1);
	assign last_r  = (r_q == mr - 1'b1);
	assign last_c0 = (c0_q == ic - mc);
	assign last_r0 = (r0_q == ir - mr);

	// Advance over mask cells, then placement columns, then placement rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q <= '0;
			c0_q <= '0;
			r_q  <= '0;
			c_q  <= '0;
		end else if (cmd.start) begin
			r0_q <= '0;
			c0_q <= '0;
			r_q  <= '0;
			c_q  <= '0;
		end else if (cmd.issue) begin
			if (!last_c) begin
				c_q <= c_q + 1'b1;
			end else begin
				c_q <= '0;
				if (!last_r) begin
					r_q <= r_q + 1'b1;
				end else begin
					r_q <= '0;
					if (!last_c0) begin
						c0_q <= c0_q + 1'b1;
					end else begin
						c0_q <= '0;
						r0_q <= r0_q + 1'b1;
					end
				end
			end
		end
	end

	// Form read and write addresses
	assign irow       = r0_q + r_q;
	assign icol       = c0_q + c_q;
	assign img_raddr  = IAW'(irow) * ICOLS + IAW'(icol);
	assign mask_raddr = MAW'(r_q) * MCOLS + MAW'(c_q);
	assign img_waddr  = IAW'(cell_row) * ICOLS + IAW'(cell_col);
	assign mask_waddr = MAW'(cell_row) * MCOLS + MAW'(cell_col);
	assign img_in_range  = (32'(cell_row) < MAX_IMAGE_ROWS) && (32'(cell_col) < MAX_IMAGE_COLS);
	assign mask_in_range = (32'(cell_row) < MAX_MASK_ROWS) && (32'(cell_col) < MAX_MASK_COLS);

	// Image memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_img && img_in_range) begin
			img_mem[img_waddr] <= cell_value;
		end
		img_s1 <= img_mem[img_raddr];
	end

	// Mask memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_mask && mask_in_range) begin
			mask_mem[mask_waddr] <= cell_value;
		end
		mask_s1 <= mask_mem[mask_raddr];
	end

	// Carry walk position flags alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		last_cell_s1 <= last_c && last_r;
		last_all_s1  <= last_c && last_r && last_c0 && last_r0;
	end

	// Compare one cell
	assign mask_nz = (mask_s1 != '0);
	assign mis     = mask_nz && (img_s1 != mask_s1);

	// Accumulate mismatch and nonzero flags over one placement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q  <= 1'b0;
			cared_q <= 1'b0;
		end else if (cmd.start || (valid_s1 && last_cell_s1)) begin
			fail_q  <= 1'b0;
			cared_q <= 1'b0;
		end else if (valid_s1) begin
			fail_q  <= fail_q || mis;
			cared_q <= cared_q || mask_nz;
		end
	end

	// Report status
	assign sts.sizes_ok   = (ir != '0) && (ic != '0) && (mr != '0) && (mc != '0) &&
	                        (mr <= ir) && (mc <= ic);
	assign sts.issue_last = last_c && last_r && last_c0 && last_r0;
	assign sts.hit        = valid_s1 && last_cell_s1 && !fail_q && !mis && (cared_q || mask_nz);
	assign sts.done       = valid_s1 && last_all_s1;

endmodule

>>> hw/rtl/m2pm_ctrl.sv
// Controller: request handshake, search sequencing and result register.
`include "masked_2d_pattern_match_assert.svh"

module m2pm_ctrl
	import m2pm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             found,
	output dp_cmd_t          cmd,
	input  dp_sts_t          sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   out_valid_q, found_q;
	logic   accept;

	// Take a word only when idle and the result slot is free or freeing
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// Drive datapath commands
	assign cmd.start   = accept && (req_type == REQ_SEARCH);
	assign cmd.wr_img  = accept && (req_type == REQ_IMAGE);
	assign cmd.wr_mask = accept && (req_type == REQ_MASK);
	assign cmd.issue   = (state_q == ST_SCAN);

	// Sequence the search and hold the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			// drop the taken result unless an immediate miss replaces it
			if (out_valid_q && out_ready && !(cmd.start && !sts.sizes_ok)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						if (sts.sizes_ok) begin
							state_q <= ST_SCAN;
						end else begin
							out_valid_q <= 1'b1;
							found_q     <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (sts.hit) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (sts.issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sts.hit) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (sts.done) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

	// Result slot stays empty while a search runs
	`M2PM_ASSERT_NOW(a_slot_empty_busy, state_q != ST_IDLE, !out_valid_q, "result held during search")
	// No store write lands during a search
	`M2PM_ASSERT_NOW(a_no_write_busy, state_q != ST_IDLE, !cmd.wr_img && !cmd.wr_mask, "write during search")
	// Last placement checked gives a result next cycle
	`M2PM_ASSERT_NEXT(a_drain_result, state_q == ST_DRAIN && sts.done, out_valid_q && state_q == ST_IDLE, "no result after walk")
	// Bad sizes give an immediate miss
	`M2PM_ASSERT_NEXT(a_bad_size_miss, cmd.start && !sts.sizes_ok, out_valid_q && !found_q, "bad sizes not reported as miss")

endmodule

>>> hw/rtl/masked_2d_pattern_match.sv
// Masked 2D pattern match. Image and mask cells are loaded one word per cycle
// while the block is idle and its result slot is free or being taken (request 0
// writes an image cell, 1 a mask cell, codes 3 are dropped); those words give no
// result. A search word (request 2) walks every placement of the mask over the
// image, one mask cell per cycle through a single read port of each memory, and
// stops early at the first placement that matches; with impossible sizes the miss
// is ready the next cycle. Zero mask cells are wildcards and an all-zero mask never
// matches. Stores come up undefined and need no clearing; write every cell in use
// before searching. The user must write the size registers only while no search
// runs; the block itself does not enforce it.
module masked_2d_pattern_match
	import m2pm_pkg::*;
#(
	parameter int MAX_IMAGE_ROWS = DEF_MAX_IMAGE_ROWS,
	parameter int MAX_IMAGE_COLS = DEF_MAX_IMAGE_COLS,
	parameter int MAX_MASK_ROWS  = DEF_MAX_MASK_ROWS,
	parameter int MAX_MASK_COLS  = DEF_MAX_MASK_COLS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [CELL_W-1:0]     cell_row,
	input  logic [CELL_W-1:0]     cell_col,
	input  logic [VAL_W-1:0]      cell_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  found
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequence requests and results
	m2pm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Store cells and compare placements
	m2pm_dpath #(
		.MAX_IMAGE_ROWS (MAX_IMAGE_ROWS),
		.MAX_IMAGE_COLS (MAX_IMAGE_COLS),
		.MAX_MASK_ROWS  (MAX_MASK_ROWS),
		.MAX_MASK_COLS  (MAX_MASK_COLS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_value (cell_value),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

>>> tb/masked_2d_pattern_match_tb.sv
// Self-checking testbench for the masked 2D pattern match block.
`timescale 1ns / 1ps

module masked_2d_pattern_match_tb;
	import m2pm_pkg::*;

	localparam int IR_MAX = DEF_MAX_IMAGE_ROWS;
	localparam int IC_MAX = DEF_MAX_IMAGE_COLS;
	localparam int MR_MAX = DEF_MAX_MASK_ROWS;
	localparam int MC_MAX = DEF_MAX_MASK_COLS;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int CLK_PERIOD    = 10;
	localparam int MAX_GAP       = 17;
	localparam int RANDOM_WORDS  = 700;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam longint LIMIT_NS  = 20_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [REQ_W-1:0]      req_type;
	logic [CELL_W-1:0]     cell_row;
	logic [CELL_W-1:0]     cell_col;
	logic [VAL_W-1:0]      cell_value;
	logic                  out_valid;
	logic                  out_ready;
	logic                  found;

	masked_2d_pattern_match u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_value (cell_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found)
	);

	// Shadow copy of the stores, the size registers and the pending search outcomes
	logic [VAL_W-1:0]    image_shadow [IR_MAX][IC_MAX];
	bit                  image_known  [IR_MAX][IC_MAX];
	logic [VAL_W-1:0]    mask_shadow  [MR_MAX][MC_MAX];
	bit                  mask_known   [MR_MAX][MC_MAX];
	logic [IMG_SZ_W-1:0] rows_img = RST_IMAGE_ROWS;
	logic [IMG_SZ_W-1:0] cols_img = RST_IMAGE_COLS;
	logic [MSK_SZ_W-1:0] rows_msk = RST_MASK_ROWS;
	logic [MSK_SZ_W-1:0] cols_msk = RST_MASK_COLS;
	bit                  found_expected [$];

	int fail_count       = 0;
	int searches_checked = 0;
	int hits_seen        = 0;
	int words_counted    = 0;
	int settings_used    = 0;
	int hold_request     = 0;
	bit calm             = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int clamp_dim(input int v, input int lim);
		return (v > lim) ? lim : v;
	endfunction

	// Give the sizes in use; return 1 when at least one placement fits
	function automatic bit sizes_in_use(output int ir, output int ic, output int mr,
			output int mc);
		ir = clamp_dim(int'(rows_img), IR_MAX);
		ic = clamp_dim(int'(cols_img), IC_MAX);
		mr = clamp_dim(int'(rows_msk), MR_MAX);
		mc = clamp_dim(int'(cols_msk), MC_MAX);
		return !(ir == 0 || ic == 0 || mr == 0 || mc == 0 || mr > ir || mc > ic);
	endfunction

	// Try every placement; zero mask cells are wildcards, an all-wildcard mask never hits
	function automatic bit predict_found();
		int ir, ic, mr, mc, cared;
		bit agree;
		if (!sizes_in_use(ir, ic, mr, mc))
			return 1'b0;
		for (int r0 = 0; r0 + mr <= ir; r0++)
			for (int c0 = 0; c0 + mc <= ic; c0++) begin
				agree = 1'b1;
				cared = 0;
				for (int r = 0; r < mr; r++)
					for (int c = 0; c < mc; c++)
						if (mask_shadow[r][c] != '0) begin
							cared++;
							if (image_shadow[r0 + r][c0 + c] != mask_shadow[r][c])
								agree = 1'b0;
						end
				if (agree && cared > 0)
					return 1'b1;
			end
		return 1'b0;
	endfunction

	// A search may only read cells that were written
	function automatic bit cells_ready();
		int ir, ic, mr, mc;
		if (!sizes_in_use(ir, ic, mr, mc))
			return 1'b1;
		for (int r = 0; r < ir; r++)
			for (int c = 0; c < ic; c++)
				if (!image_known[r][c])
					return 1'b0;
		for (int r = 0; r < mr; r++)
			for (int c = 0; c < mc; c++)
				if (!mask_known[r][c])
					return 1'b0;
		return 1'b1;
	endfunction

	// Zero alphabet means any byte; otherwise a few small values so placements hit
	function automatic logic [VAL_W-1:0] pick_value(input int alphabet);
		if (alphabet == 0)
			return VAL_W'($urandom_range(0, 255));
		if ($urandom_range(0, 7) == 0)
			return '0;
		return VAL_W'($urandom_range(1, alphabet));
	endfunction

	// Offer one word, wait for it to be taken, then mirror it into the shadow state
	task automatic send_word(input logic [REQ_W-1:0] kind, input logic [CELL_W-1:0] row,
			input logic [CELL_W-1:0] col, input logic [VAL_W-1:0] val);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		cell_row   <= row;
		cell_col   <= col;
		cell_value <= val;
		do @(posedge clk); while (in_ready !== 1'b1);
		words_counted++;
		case (kind)
			REQ_IMAGE: begin
				if (row < IR_MAX && col < IC_MAX) begin
					image_shadow[row][col] = val;
					image_known[row][col]  = 1'b1;
				end
			end
			REQ_MASK: begin
				if (row < MR_MAX && col < MC_MAX) begin
					mask_shadow[row][col] = val;
					mask_known[row][col]  = 1'b1;
				end
			end
			REQ_SEARCH: begin
				found_expected.push_back(predict_found());
			end
			default: ;
		endcase
	endtask

	task automatic request_search();
		if (cells_ready())
			send_word(REQ_SEARCH, CELL_W'($urandom), CELL_W'($urandom), VAL_W'($urandom));
	endtask

	// Drop valid, wait for every search outcome, then let trailing writes land
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (found_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_IMAGE_ROWS: rows_img = data[IMG_SZ_W-1:0];
			REG_IMAGE_COLS: cols_img = data[IMG_SZ_W-1:0];
			REG_MASK_ROWS:  rows_msk = data[MSK_SZ_W-1:0];
			REG_MASK_COLS:  cols_msk = data[MSK_SZ_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_sizes(input int ir, input int ic, input int mr, input int mc);
		wait_drained();
		write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(ir));
		write_reg(REG_IMAGE_COLS, CFG_DATA_W'(ic));
		write_reg(REG_MASK_ROWS, CFG_DATA_W'(mr));
		write_reg(REG_MASK_COLS, CFG_DATA_W'(mc));
		settings_used++;
	endtask

	// Write unwritten cells in use, and refresh about a quarter of the others
	task automatic fill_in_use(input int alphabet);
		int ir, ic, mr, mc;
		void'(sizes_in_use(ir, ic, mr, mc));
		for (int r = 0; r < ir; r++)
			for (int c = 0; c < ic; c++)
				if (!image_known[r][c] || $urandom_range(0, 3) == 0)
					send_word(REQ_IMAGE, CELL_W'(r), CELL_W'(c), pick_value(alphabet));
		for (int r = 0; r < mr; r++)
			for (int c = 0; c < mc; c++)
				if (!mask_known[r][c] || $urandom_range(0, 3) == 0)
					send_word(REQ_MASK, CELL_W'(r), CELL_W'(c), pick_value(alphabet));
	endtask

	// Copy an image region into the mask; a negative corner means a random one
	task automatic plant_mask(input int wild_pct, input int at_row, input int at_col);
		int ir, ic, mr, mc, r0, c0;
		logic [VAL_W-1:0] v;
		if (!sizes_in_use(ir, ic, mr, mc))
			return;
		r0 = (at_row < 0) ? $urandom_range(0, ir - mr) : at_row;
		c0 = (at_col < 0) ? $urandom_range(0, ic - mc) : at_col;
		for (int r = 0; r < mr; r++)
			for (int c = 0; c < mc; c++) begin
				v = ($urandom_range(1, 100) <= wild_pct) ? '0 : image_shadow[r0 + r][c0 + c];
				send_word(REQ_MASK, CELL_W'(r), CELL_W'(c), v);
			end
	endtask

	// Mixed traffic: searches, rewrites in use, planted masks, stray writes and unused codes
	task automatic run_mix(input int n, input int alphabet);
		int ir, ic, mr, mc, pick;
		void'(sizes_in_use(ir, ic, mr, mc));
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				request_search();
			else if (pick < 45 && ir > 0 && ic > 0)
				send_word(REQ_IMAGE, CELL_W'($urandom_range(0, ir - 1)),
					CELL_W'($urandom_range(0, ic - 1)), pick_value(alphabet));
			else if (pick < 62 && mr > 0 && mc > 0)
				send_word(REQ_MASK, CELL_W'($urandom_range(0, mr - 1)),
					CELL_W'($urandom_range(0, mc - 1)), pick_value(alphabet));
			else if (pick < 67)
				plant_mask(25, -1, -1);
			else if (pick < 78)
				send_word(REQ_IMAGE, CELL_W'($urandom), CELL_W'($urandom), VAL_W'($urandom));
			else if (pick < 90)
				send_word(REQ_MASK, CELL_W'($urandom), CELL_W'($urandom), VAL_W'($urandom));
			else
				send_word(REQ_UNUSED, CELL_W'($urandom), CELL_W'($urandom), VAL_W'($urandom));
		end
	endtask

	// Column registers keep their reset values; a hit needs the full 64 x 8 reach
	task automatic test_reset_sizes();
		write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(1));
		write_reg(REG_MASK_ROWS, CFG_DATA_W'(1));
		settings_used++;
		for (int c = 0; c < IC_MAX; c++)
			send_word(REQ_IMAGE, '0, CELL_W'(c), VAL_W'($urandom_range(1, 255)));
		for (int c = 0; c < MC_MAX; c++)
			send_word(REQ_MASK, '0, CELL_W'(c), image_shadow[0][IC_MAX - MC_MAX + c]);
		// writes outside the mask store and the unused code must be dropped
		send_word(REQ_MASK, '0, CELL_W'(9), 8'h5A);
		send_word(REQ_MASK, 6'h3F, '0, 8'hC3);
		send_word(REQ_UNUSED, 6'h3F, 6'h3F, 8'hFF);
		request_search();
	endtask

	// Oversized registers clamp to the store sizes: a tall one-column image
	task automatic test_clamped_sizes();
		set_sizes(127, 1, 15, 1);
		for (int r = 0; r < IR_MAX; r++)
			send_word(REQ_IMAGE, CELL_W'(r), '0, VAL_W'($urandom_range(1, 254)));
		plant_mask(0, IR_MAX - MR_MAX, 0);
		request_search();
		send_word(REQ_MASK, CELL_W'(MR_MAX - 1), '0, image_shadow[IR_MAX - 1][0] + 8'd1);
		request_search();
		send_word(REQ_IMAGE, 6'h3F, 6'h3F, 8'h00);
	endtask

	// Wildcards, zero sizes, oversized mask, exact fit and a single cell
	task automatic test_special_sizes();
		set_sizes(4, 4, 2, 2);
		fill_in_use(2);
		plant_mask(100, -1, -1);
		request_search();
		plant_mask(0, -1, -1);
		request_search();
		set_sizes(4, 4, 0, 2);
		request_search();
		set_sizes(4, 4, 2, 0);
		request_search();
		set_sizes(0, 4, 2, 2);
		request_search();
		set_sizes(4, 0, 2, 2);
		request_search();
		set_sizes(4, 4, 5, 2);
		request_search();
		set_sizes(4, 4, 4, 4);
		fill_in_use(2);
		plant_mask(25, 0, 0);
		request_search();
		set_sizes(4, 4, 1, 1);
		send_word(REQ_MASK, '0, '0, image_shadow[3][3]);
		request_search();
		send_word(REQ_MASK, '0, '0, 8'd200);
		request_search();
	endtask

	// No idling on either side
	task automatic test_back_to_back();
		set_sizes(6, 6, 2, 3);
		calm = 1'b1;
		fill_in_use(3);
		plant_mask(20, -1, -1);
		run_mix(30, 3);
		calm = 1'b0;
	endtask

	// Hold off the result side while searches keep coming, so the input stalls
	task automatic test_output_stall();
		set_sizes(5, 5, 1, 2);
		fill_in_use(2);
		plant_mask(0, -1, -1);
		calm = 1'b1;
		hold_request = HOLD_CYCLES;
		repeat (6) begin
			request_search();
			send_word(REQ_IMAGE, CELL_W'($urandom_range(0, 4)), CELL_W'($urandom_range(0, 4)),
				pick_value(2));
		end
		calm = 1'b0;
	endtask

	// Random size settings, each with a fill, mostly a planted mask, and mixed traffic
	task automatic test_random_phases();
		int ir, ic, mr, mc, alphabet, start_words;
		start_words = words_counted;
		while (words_counted - start_words < RANDOM_WORDS) begin
			case ($urandom_range(0, 15))
				0: begin
					ir = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
					ic = $urandom_range(1, 2);
					mr = $urandom_range(1, 8);
					mc = $urandom_range(1, ic);
				end
				1: begin
					ir = $urandom_range(1, 2);
					ic = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
					mr = $urandom_range(1, ir);
					mc = $urandom_range(1, 8);
				end
				2: begin
					ir = $urandom_range(1, 6);
					ic = $urandom_range(1, 6);
					mr = $urandom_range(1, 3);
					mc = $urandom_range(1, 3);
					case ($urandom_range(0, 4))
						0: ir = 0;
						1: ic = 0;
						2: mr = 0;
						3: mc = 0;
						default: mr = $urandom_range(ir + 1, 8);
					endcase
				end
				default: begin
					ir = $urandom_range(1, 12);
					ic = $urandom_range(1, 12);
					mr = $urandom_range(1, clamp_dim(ir, MR_MAX));
					mc = $urandom_range(1, clamp_dim(ic, MC_MAX));
					if ($urandom_range(0, 9) == 0 && ir >= MR_MAX)
						mr = $urandom_range(9, 15);
				end
			endcase
			// upper data bits of a mask register are not part of the size
			if ($urandom_range(0, 7) == 0)
				mc = mc | ($urandom_range(1, 7) << MSK_SZ_W);
			set_sizes(ir, ic, mr, mc);
			calm = ($urandom_range(0, 3) == 0);
			alphabet = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 4);
			fill_in_use(alphabet);
			if ($urandom_range(0, 2) != 0)
				plant_mask(25, -1, -1);
			run_mix($urandom_range(20, 60), alphabet);
		end
		calm = 1'b0;
	endtask

	// Result side: random stalls, long hold-off on request, check each result word
	initial begin : result_sink
		int stall_left;
		int hold_left;
		bit want;
		stall_left = 0;
		hold_left  = 0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (found_expected.size() == 0) begin
					$error("found: expected no result, actual %0b", found);
					fail_count++;
				end else begin
					want = found_expected.pop_front();
					searches_checked++;
					if (want)
						hits_seen++;
					if (found !== want) begin
						$error("found: expected %0b, actual %0b", want, found);
						fail_count++;
					end
				end
				stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		req_type   = '0;
		cell_row   = '0;
		cell_col   = '0;
		cell_value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_clamped_sizes();
		test_special_sizes();
		test_back_to_back();
		test_output_stall();
		test_random_phases();
		wait_drained();

		$display("Covered %0d size settings with %0d input words.",
			settings_used, words_counted);
		$display("Checked %0d search results, %0d predicted hits.", searches_checked, hits_seen);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> masked_2d_pattern_match.f
+incdir+hw/rtl
hw/rtl/m2pm_pkg.sv
hw/rtl/m2pm_dpath.sv
hw/rtl/m2pm_ctrl.sv
hw/rtl/masked_2d_pattern_match.sv
tb/masked_2d_pattern_match_tb.sv
